// ===== sv/tlckb_pkg.sv =====
// ----------------------------------------------------------------------------
// tlckb_pkg
// Shared constants and types of the two-layer color key blender.
// ----------------------------------------------------------------------------
package tlckb_pkg;

    localparam int unsigned CHAN_W    = 8;
    localparam int unsigned PIXEL_W   = 3 * CHAN_W;
    localparam int unsigned OPAC_W    = 7;
    localparam int unsigned DEPTH_W   = 8;
    localparam int unsigned WEIGHT_W  = 9;
    localparam int unsigned ADDR_W    = 5;
    localparam int unsigned IDX_W     = 3;
    localparam int unsigned DIV_NUM_W = 16;
    localparam int unsigned DIV_CNT_W = 4;

    localparam logic [OPAC_W-1:0]    OPACITY_FULL = 7'd100;
    localparam logic [WEIGHT_W-1:0]  WEIGHT_HALF  = 9'd128;
    localparam logic [WEIGHT_W-1:0]  WEIGHT_ONE   = 9'd256;
    localparam logic [DIV_CNT_W-1:0] DIV_STEPS    = 4'd9;

    localparam logic [IDX_W-1:0] REG_FIRST_OPACITY  = 3'd0;
    localparam logic [IDX_W-1:0] REG_SECOND_OPACITY = 3'd1;
    localparam logic [IDX_W-1:0] REG_FIRST_DEPTH    = 3'd2;
    localparam logic [IDX_W-1:0] REG_SECOND_DEPTH   = 3'd3;
    localparam logic [IDX_W-1:0] REG_KEY_COLOR      = 3'd4;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } rgb_t;

    function automatic logic [CHAN_W-1:0] mix_chan(
        input logic [CHAN_W-1:0]   a,
        input logic [CHAN_W-1:0]   b,
        input logic [WEIGHT_W-1:0] w
    );
        logic [WEIGHT_W-1:0]   wb;
        logic [DIV_NUM_W-1:0]  sum;
        wb  = WEIGHT_ONE - w;
        sum = DIV_NUM_W'(a * w) + DIV_NUM_W'(b * wb);
        return sum[DIV_NUM_W-1 -: CHAN_W];
    endfunction

endpackage

// ===== sv/two_layer_color_key_blend_top.sv =====
// ----------------------------------------------------------------------------
// two_layer_color_key_blend_top
// Composites one pixel pair per word from two RGB888 layers with color key,
// depth order and opacity weighting.
// ----------------------------------------------------------------------------
// Path: each word passes the input register and then the result register.
// Throughput: 1 word per cycle while m_tready allows; after an opacity write the
// input stalls while the radix-2 weight divider runs one bit per cycle.
// Reset: synchronous, active low; all registers read 0 and weight is 128.
module two_layer_color_key_blend_top
    import tlckb_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    // APB configuration
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_W-1:0]    paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    // input stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // first_red, first_green, first_blue, second_red, second_green, second_blue
    input  logic [2*PIXEL_W-1:0] s_tdata,
    // result stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // mixed_red, mixed_green, mixed_blue
    output logic [PIXEL_W-1:0]   m_tdata,
    // settings_ok
    output logic [0:0]           m_tuser
);

    logic [OPAC_W-1:0]  first_opacity_reg, second_opacity_reg;
    logic [DEPTH_W-1:0] first_depth_reg, second_depth_reg;
    logic [PIXEL_W-1:0] key_color_reg;
    logic [WEIGHT_W-1:0] weight_reg;

    logic                 div_load_reg, div_busy_reg;
    logic [WEIGHT_W-1:0]  div_rem_reg, div_den_reg, div_quo_reg;
    logic [WEIGHT_W-1:0]  div_num_reg;
    logic [DIV_CNT_W-1:0] div_cnt_reg;

    logic                 s1_valid_reg;
    logic [2*PIXEL_W-1:0] s1_pix_reg;
    logic                 m_valid_reg;
    logic [PIXEL_W-1:0]   m_data_reg;
    logic                 m_ok_reg;

    logic               cfg_wr;
    logic [IDX_W-1:0]   cfg_idx;
    logic               adv;
    logic               s_accept;

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign cfg_idx  = paddr[ADDR_W-1:2];
    assign adv      = !m_valid_reg || m_tready;
    assign s_tready = adv && !div_load_reg && !div_busy_reg;
    assign s_accept = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_ok_reg;

    always_comb begin
        unique case (cfg_idx)
            REG_FIRST_OPACITY:  prdata = 32'(first_opacity_reg);
            REG_SECOND_OPACITY: prdata = 32'(second_opacity_reg);
            REG_FIRST_DEPTH:    prdata = 32'(first_depth_reg);
            REG_SECOND_DEPTH:   prdata = 32'(second_depth_reg);
            REG_KEY_COLOR:      prdata = 32'(key_color_reg);
            default:            prdata = 32'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_opacity_reg  <= '0;
            second_opacity_reg <= '0;
            first_depth_reg    <= '0;
            second_depth_reg   <= '0;
            key_color_reg      <= '0;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_FIRST_OPACITY:  first_opacity_reg  <= pwdata[OPAC_W-1:0];
                REG_SECOND_OPACITY: second_opacity_reg <= pwdata[OPAC_W-1:0];
                REG_FIRST_DEPTH:    first_depth_reg    <= pwdata[DEPTH_W-1:0];
                REG_SECOND_DEPTH:   second_depth_reg   <= pwdata[DEPTH_W-1:0];
                REG_KEY_COLOR:      key_color_reg      <= pwdata[PIXEL_W-1:0];
                default: ;
            endcase
        end
    end

    // weight = floor((t1*512 + s) / (2*s)), or 128 when s is 0; one quotient bit per cycle
    logic [DEPTH_W-1:0]   op_sum;
    logic [DIV_NUM_W-1:0] div_num_full;
    logic [WEIGHT_W:0]    div_trial;
    logic                 div_take;
    logic [WEIGHT_W-1:0]  div_quo_next;

    assign op_sum       = DEPTH_W'(first_opacity_reg) + DEPTH_W'(second_opacity_reg);
    assign div_num_full = {first_opacity_reg, 9'd0} + DIV_NUM_W'(op_sum);
    assign div_trial    = {div_rem_reg, div_num_reg[WEIGHT_W-1]};
    assign div_take     = div_trial >= {1'b0, div_den_reg};
    assign div_quo_next = {div_quo_reg[WEIGHT_W-2:0], div_take};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_load_reg <= 1'b0;
            div_busy_reg <= 1'b0;
            weight_reg   <= WEIGHT_HALF;
        end else begin
            div_load_reg <= cfg_wr && (cfg_idx == REG_FIRST_OPACITY ||
                                       cfg_idx == REG_SECOND_OPACITY);
            if (div_load_reg) begin
                if (op_sum == '0) begin
                    div_busy_reg <= 1'b0;
                    weight_reg   <= WEIGHT_HALF;
                end else begin
                    div_busy_reg <= 1'b1;
                end
            end else if (div_busy_reg && div_cnt_reg == 4'd1) begin
                div_busy_reg <= 1'b0;
                weight_reg   <= div_quo_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (div_load_reg) begin
            div_rem_reg <= WEIGHT_W'(div_num_full[DIV_NUM_W-1:WEIGHT_W]);
            div_num_reg <= div_num_full[WEIGHT_W-1:0];
            div_den_reg <= {op_sum, 1'b0};
            div_quo_reg <= '0;
            div_cnt_reg <= DIV_STEPS;
        end else if (div_busy_reg) begin
            div_rem_reg <= div_take ? WEIGHT_W'(div_trial - {1'b0, div_den_reg})
                                    : div_trial[WEIGHT_W-1:0];
            div_num_reg <= {div_num_reg[WEIGHT_W-2:0], 1'b0};
            div_quo_reg <= div_quo_next;
            div_cnt_reg <= div_cnt_reg - 4'd1;
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (adv) begin
            s1_valid_reg <= s_accept;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_pix_reg <= s_tdata;
        end
    end

    // composite
    rgb_t p1, p2, mixed, src;
    logic opac_bad, l2_front, l2_wins, l1_wins;

    assign p1 = '{red: s1_pix_reg[7:0], green: s1_pix_reg[15:8],
                  blue: s1_pix_reg[23:16]};
    assign p2 = '{red: s1_pix_reg[31:24], green: s1_pix_reg[39:32],
                  blue: s1_pix_reg[47:40]};

    assign opac_bad = first_opacity_reg > OPACITY_FULL || second_opacity_reg > OPACITY_FULL;
    assign l2_front = first_depth_reg > second_depth_reg;
    assign l2_wins  = l2_front && second_opacity_reg == OPACITY_FULL;
    assign l1_wins  = !l2_front && first_opacity_reg == OPACITY_FULL;

    assign mixed.red   = mix_chan(p1.red, p2.red, weight_reg);
    assign mixed.green = mix_chan(p1.green, p2.green, weight_reg);
    assign mixed.blue  = mix_chan(p1.blue, p2.blue, weight_reg);

    always_comb begin
        if (opac_bad) begin
            src = '0;
        end else if (l2_wins) begin
            src = (p1 == p2 || p2 == key_color_reg) ? p1 : p2;
        end else if (l1_wins) begin
            src = (p1 != p2 && p1 == key_color_reg) ? p2 : p1;
        end else if (p1 == key_color_reg) begin
            src = p2;
        end else if (p2 == key_color_reg) begin
            src = p1;
        end else begin
            src = mixed;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && s1_valid_reg) begin
            m_data_reg <= {src.blue, src.green, src.red};
            m_ok_reg   <= !opac_bad;
        end
    end

    a_no_accept_while_dividing: assert property (@(posedge aclk) disable iff (!aresetn)
        (div_busy_reg || div_load_reg) |-> !s_tready)
        else $error("input accepted while weight divider runs");

    a_bad_settings_black: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ok_reg) |-> m_data_reg == '0)
        else $error("invalid opacity result carries color");

    a_weight_range: assert property (@(posedge aclk) disable iff (!aresetn)
        weight_reg <= WEIGHT_ONE)
        else $error("blend weight above one");

    a_divider_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (div_busy_reg && div_cnt_reg == 4'd1 && !div_load_reg) |=> !div_busy_reg)
        else $error("weight divider did not finish");

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Pixel-stream check of the two-layer color key blender. Pixel pairs are
// streamed through the input channel under a series of opacity, depth and
// key settings written over APB; every result word is compared with an
// in-bench compositor model that covers invalid opacities, the opaque front
// layer, color key replacement and weighted mixing.
// ----------------------------------------------------------------------------
module tb;
    import tlckb_pkg::*;

    localparam int unsigned RANDOM_SETTINGS = 15;
    localparam int unsigned WORDS_PER_SETTING = 110;

    typedef struct packed {
        logic [CHAN_W-1:0] second_blue;
        logic [CHAN_W-1:0] second_green;
        logic [CHAN_W-1:0] second_red;
        logic [CHAN_W-1:0] first_blue;
        logic [CHAN_W-1:0] first_green;
        logic [CHAN_W-1:0] first_red;
    } pixel_pair_t;

    typedef struct packed {
        logic              settings_ok;
        logic [CHAN_W-1:0] mixed_blue;
        logic [CHAN_W-1:0] mixed_green;
        logic [CHAN_W-1:0] mixed_red;
    } mixed_word_t;

    typedef enum logic [1:0] {SRC_FIRST, SRC_SECOND, SRC_MIX} pixel_src_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [ADDR_W-1:0]    paddr = '0;
    logic [31:0]          pwdata = '0;
    logic [31:0]          prdata;
    logic                 pready;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [2*PIXEL_W-1:0] s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [PIXEL_W-1:0]   m_tdata;
    logic [0:0]           m_tuser;

    logic [OPAC_W-1:0]   cfg_opacity1 = '0;
    logic [OPAC_W-1:0]   cfg_opacity2 = '0;
    logic [DEPTH_W-1:0]  cfg_depth1 = '0;
    logic [DEPTH_W-1:0]  cfg_depth2 = '0;
    logic [PIXEL_W-1:0]  cfg_key = '0;
    logic [WEIGHT_W-1:0] cfg_weight = WEIGHT_HALF;

    pixel_pair_t pixel_q[$];
    mixed_word_t pending_mix_q[$];
    int unsigned pairs_queued = 0;
    int unsigned pairs_taken = 0;
    int unsigned error_cnt = 0;
    int unsigned send_idle_pct = 11;
    int unsigned recv_stall_pct = 67;

    two_layer_color_key_blend_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic logic [WEIGHT_W-1:0] weight_of(input logic [OPAC_W-1:0] t1,
                                                       input logic [OPAC_W-1:0] t2);
        int unsigned s;
        s = t1 + t2;
        if (s == 0) begin
            return WEIGHT_HALF;
        end
        return WEIGHT_W'((t1 * 512 + s) / (2 * s));
    endfunction

    function automatic logic [CHAN_W-1:0] mix_value(input logic [CHAN_W-1:0] a,
                                                    input logic [CHAN_W-1:0] b);
        int unsigned sum;
        sum = a * cfg_weight + b * (256 - cfg_weight);
        return CHAN_W'(sum >> 8);
    endfunction

    function automatic mixed_word_t composite(input pixel_pair_t pp);
        logic [PIXEL_W-1:0] p1;
        logic [PIXEL_W-1:0] p2;
        pixel_src_t         src;
        mixed_word_t        r;
        p1 = {pp.first_red, pp.first_green, pp.first_blue};
        p2 = {pp.second_red, pp.second_green, pp.second_blue};
        r = '0;
        if (cfg_opacity1 > OPACITY_FULL || cfg_opacity2 > OPACITY_FULL) begin
            return r;
        end
        r.settings_ok = 1'b1;
        if (cfg_depth1 > cfg_depth2 && cfg_opacity2 == OPACITY_FULL) begin
            src = (p1 == p2 || p2 == cfg_key) ? SRC_FIRST : SRC_SECOND;
        end else if (cfg_depth1 <= cfg_depth2 && cfg_opacity1 == OPACITY_FULL) begin
            src = (p1 != p2 && p1 == cfg_key) ? SRC_SECOND : SRC_FIRST;
        end else if (p1 == cfg_key) begin
            src = SRC_SECOND;
        end else if (p2 == cfg_key) begin
            src = SRC_FIRST;
        end else begin
            src = SRC_MIX;
        end
        case (src)
            SRC_FIRST: begin
                r.mixed_red   = pp.first_red;
                r.mixed_green = pp.first_green;
                r.mixed_blue  = pp.first_blue;
            end
            SRC_SECOND: begin
                r.mixed_red   = pp.second_red;
                r.mixed_green = pp.second_green;
                r.mixed_blue  = pp.second_blue;
            end
            default: begin
                r.mixed_red   = mix_value(pp.first_red, pp.second_red);
                r.mixed_green = mix_value(pp.first_green, pp.second_green);
                r.mixed_blue  = mix_value(pp.first_blue, pp.second_blue);
            end
        endcase
        return r;
    endfunction

    function automatic pixel_pair_t make_pair(input logic [PIXEL_W-1:0] p1,
                                              input logic [PIXEL_W-1:0] p2);
        pixel_pair_t pp;
        {pp.first_red, pp.first_green, pp.first_blue} = p1;
        {pp.second_red, pp.second_green, pp.second_blue} = p2;
        return pp;
    endfunction

    function automatic pixel_pair_t random_pair();
        pixel_pair_t pp;
        int unsigned sel;
        pp = pixel_pair_t'(48'({$urandom(), $urandom()}));
        sel = $urandom_range(99);
        if (sel < 18) begin
            {pp.first_red, pp.first_green, pp.first_blue} = cfg_key;
        end else if (sel < 36) begin
            {pp.second_red, pp.second_green, pp.second_blue} = cfg_key;
        end else if (sel < 46) begin
            {pp.second_red, pp.second_green, pp.second_blue} =
                {pp.first_red, pp.first_green, pp.first_blue};
        end else if (sel < 52) begin
            pp = make_pair(cfg_key, cfg_key);
        end else if (sel < 60) begin
            for (int i = 0; i < 6; i++) begin
                pp[i*CHAN_W +: CHAN_W] = $urandom_range(1) ? 8'hFF : 8'h00;
            end
        end
        return pp;
    endfunction

    function automatic logic [OPAC_W-1:0] random_opacity();
        int unsigned sel;
        sel = $urandom_range(99);
        if (sel < 15) begin
            return OPACITY_FULL;
        end else if (sel < 25) begin
            return OPAC_W'($urandom_range(127, 101));
        end else if (sel < 32) begin
            return '0;
        end
        return OPAC_W'($urandom_range(100));
    endfunction

    task automatic push_pair(input pixel_pair_t pp);
        pixel_q.push_back(pp);
        pairs_queued++;
    endtask

    task automatic push_key_cases(input logic [PIXEL_W-1:0] key);
        logic [PIXEL_W-1:0] other;
        other = key ^ 24'h5A5AA5;
        push_pair(make_pair(key, key));
        push_pair(make_pair(key, other));
        push_pair(make_pair(other, key));
        push_pair(make_pair(other, other ^ 24'h0F0F0F));
    endtask

    task automatic drain();
        while (pairs_taken != pairs_queued || pending_mix_q.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [31:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_FIRST_OPACITY:  cfg_opacity1 = value[OPAC_W-1:0];
            REG_SECOND_OPACITY: cfg_opacity2 = value[OPAC_W-1:0];
            REG_FIRST_DEPTH:    cfg_depth1 = value[DEPTH_W-1:0];
            REG_SECOND_DEPTH:   cfg_depth2 = value[DEPTH_W-1:0];
            REG_KEY_COLOR:      cfg_key = value[PIXEL_W-1:0];
            default: ;
        endcase
        cfg_weight = weight_of(cfg_opacity1, cfg_opacity2);
    endtask

    // upper register bits carry junk to exercise masking
    task automatic program_layers(input logic [OPAC_W-1:0]  t1,
                                  input logic [OPAC_W-1:0]  t2,
                                  input logic [DEPTH_W-1:0] d1,
                                  input logic [DEPTH_W-1:0] d2,
                                  input logic [PIXEL_W-1:0] key);
        drain();
        write_reg(REG_FIRST_OPACITY, ($urandom() & ~32'h7F) | t1);
        write_reg(REG_SECOND_OPACITY, ($urandom() & ~32'h7F) | t2);
        write_reg(REG_FIRST_DEPTH, ($urandom() & ~32'hFF) | d1);
        write_reg(REG_SECOND_DEPTH, ($urandom() & ~32'hFF) | d2);
        write_reg(REG_KEY_COLOR, ($urandom() & ~32'hFFFFFF) | key);
    endtask

    task automatic report_field(input string name, input int unsigned exp_v,
                                input int unsigned got_v);
        if (exp_v != got_v) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, got_v);
            error_cnt++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (s_tvalid) begin
                pending_mix_q.push_back(composite(pixel_pair_t'(s_tdata)));
                pairs_taken++;
            end
            if (pixel_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                s_tdata  <= pixel_q.pop_front();
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        mixed_word_t exp_w;
        mixed_word_t got_w;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got_w = {m_tuser[0], m_tdata};
                if (pending_mix_q.size() == 0) begin
                    $display("%0t: unexpected word %h", $time, got_w);
                    error_cnt++;
                end else begin
                    exp_w = pending_mix_q.pop_front();
                    report_field("mixed_red", exp_w.mixed_red, got_w.mixed_red);
                    report_field("mixed_green", exp_w.mixed_green, got_w.mixed_green);
                    report_field("mixed_blue", exp_w.mixed_blue, got_w.mixed_blue);
                    report_field("settings_ok", exp_w.settings_ok, got_w.settings_ok);
                end
            end
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial begin
        logic [DEPTH_W-1:0] d1;
        logic [DEPTH_W-1:0] d2;
        logic [PIXEL_W-1:0] key;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // unmapped register: must change nothing
        write_reg(IDX_W'(REG_KEY_COLOR + 1 + $urandom_range(2)), $urandom());
        push_pair(make_pair(24'h000000, 24'h000000));
        push_pair(make_pair(24'hFFFFFF, 24'h000000));
        push_pair(make_pair(24'h000000, 24'hFFFFFF));
        push_pair(make_pair(24'hFFFFFF, 24'hFFFFFF));
        push_pair(make_pair(24'hFFFFFF, 24'h010101));
        push_pair(make_pair(24'h804020, 24'h010203));
        push_pair(make_pair(24'h010203, 24'hFFFEFD));
        push_pair(random_pair());
        program_layers(OPACITY_FULL, OPACITY_FULL, 8'd5, 8'd5, 24'h123456);
        push_key_cases(cfg_key);
        program_layers(OPACITY_FULL, OPACITY_FULL, 8'd9, 8'd3, 24'hA5C3E1);
        push_key_cases(cfg_key);
        program_layers(7'd40, 7'd60, 8'd9, 8'd3, 24'h00FF00);
        push_key_cases(cfg_key);

        for (int k = 0; k < RANDOM_SETTINGS; k++) begin
            d1  = DEPTH_W'($urandom());
            d2  = ($urandom_range(4) == 0) ? d1 : DEPTH_W'($urandom());
            key = ($urandom_range(3) == 0) ? ($urandom_range(1) ? 24'hFFFFFF : 24'h0)
                                           : PIXEL_W'($urandom());
            case (k)
                0:  program_layers(7'd0, 7'd0, 8'd0, 8'd0, 24'h000000);
                1:  program_layers(OPACITY_FULL, OPACITY_FULL, 8'd0, 8'd0, 24'hFFFFFF);
                2:  program_layers(OPACITY_FULL, 7'd37, 8'd255, 8'd0, key);
                3:  program_layers(OPACITY_FULL, OPACITY_FULL, 8'd255, 8'd0, key);
                4:  program_layers(7'd101, 7'd50, d1, d2, key);
                5:  program_layers(7'd127, 7'd127, d1, d2, key);
                6:  program_layers(7'd0, OPACITY_FULL, 8'd3, 8'd200, key);
                7:  program_layers(7'd1, OPACITY_FULL, 8'd200, 8'd3, key);
                8:  program_layers(OPACITY_FULL, 7'd0, 8'd7, 8'd7, key);
                9:  program_layers(7'd50, 7'd127, d1, d2, key);
                default: program_layers(random_opacity(), random_opacity(), d1, d2, key);
            endcase
            if (k == 5) begin
                send_idle_pct  = 67;
                recv_stall_pct = 11;
            end else if (k == 10) begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            for (int n = 0; n < WORDS_PER_SETTING; n++) begin
                push_pair(random_pair());
            end
        end

        drain();
        repeat (10) @(posedge aclk);
        if (error_cnt == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== files.f =====
sv/tlckb_pkg.sv
sv/two_layer_color_key_blend_top.sv
sim/tb.sv
